[rtl/core/tmng_pkg.sv]
package tmng_pkg;

	// symbol and table geometry
	localparam int unsigned ALPHA   = 26;
	localparam int unsigned SYMS    = ALPHA + 1;
	localparam int unsigned ROWW    = ALPHA + 2;
	localparam int unsigned DEPTH   = SYMS * SYMS * ROWW;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam logic [4:0]  BOUNDARY = 5'(ALPHA);
	localparam logic [4:0]  TOT_SLOT = 5'(ALPHA + 1);

	typedef enum logic [1:0] {
		OP_LEARN_LETTER = 2'd0,
		OP_LEARN_END    = 2'd1,
		OP_DRAW         = 2'd2,
		OP_SPARE        = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_LEARNED  = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_LETTER   = 3'd2,
		ST_DONE     = 3'd3,
		ST_REJECTED = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	localparam logic REG_MIN_LENGTH = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  letter;
		logic [31:0] random_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] out_letter;
		logic [5:0] word_length;
		logic       word_discarded;
	} out_item_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_TOT, S_WAIT_TOT, S_LRN_INC_TOT, S_LRN_RD_SYM,
		S_LRN_WAIT_SYM, S_LRN_INC_SYM, S_DIV, S_WALK_RD, S_WALK_CHK, S_FINISH, S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic clr_step;
		logic rd_total;
		logic wr_total_inc;
		logic rd_sym;
		logic wr_sym_inc;
		logic div_start;
		logic div_step;
		logic ld_total;
		logic walk_chk;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic is_draw;
		logic bad_letter;
		logic total_full;
		logic total_zero;
		logic div_done;
		logic walk_hit;
	} sts_t;

	function automatic logic is_vowel(input logic [4:0] s);
		return (s == 5'd0) || (s == 5'd4) || (s == 5'd8) || (s == 5'd14) || (s == 5'd20);
	endfunction

endpackage

[rtl/core/tmng_ram.sv]
module tmng_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/core/tmng_ctrl.sv]
module tmng_ctrl import tmng_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:        if (sts.clr_done) state_d = S_IDLE;
			S_IDLE:         if (in_valid) state_d = S_RD_TOT;
			S_RD_TOT:       state_d = S_WAIT_TOT;
			S_WAIT_TOT: begin
				if (sts.is_draw)
					state_d = sts.total_zero ? S_FINISH : S_DIV;
				else if (sts.bad_letter || sts.total_full)
					state_d = S_FINISH;
				else
					state_d = S_LRN_INC_TOT;
			end
			S_LRN_INC_TOT:  state_d = S_LRN_RD_SYM;
			S_LRN_RD_SYM:   state_d = S_LRN_WAIT_SYM;
			S_LRN_WAIT_SYM: state_d = S_LRN_INC_SYM;
			S_LRN_INC_SYM:  state_d = S_FINISH;
			S_DIV:          if (sts.div_done) state_d = S_WALK_RD;
			S_WALK_RD:      state_d = S_WALK_CHK;
			S_WALK_CHK:     state_d = sts.walk_hit ? S_FINISH : S_WALK_RD;
			S_FINISH:       state_d = S_OUT;
			S_OUT:          if (!out_stall) state_d = S_IDLE;
			default:        state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		out_valid = (state_q == S_OUT);
		case (state_q)
			S_CLEAR:        cmd.clr_step = 1'b1;
			S_IDLE:         cmd.load_item = in_valid;
			S_RD_TOT:       cmd.rd_total = 1'b1;
			S_WAIT_TOT: begin
				cmd.ld_total = 1'b1;
				cmd.div_start = sts.is_draw;
			end
			S_LRN_INC_TOT:  cmd.wr_total_inc = 1'b1;
			// hold the symbol address so its count is still read out when incremented
			S_LRN_RD_SYM:   cmd.rd_sym = 1'b1;
			S_LRN_WAIT_SYM: cmd.rd_sym = 1'b1;
			S_LRN_INC_SYM:  cmd.wr_sym_inc = 1'b1;
			S_DIV:          cmd.div_step = 1'b1;
			S_WALK_CHK:     cmd.walk_chk = 1'b1;
			S_FINISH:       cmd.finish = 1'b1;
			default:        ;
		endcase
	end
endmodule

[rtl/core/tmng_dp.sv]
module tmng_dp import tmng_pkg::*; #(
	parameter int unsigned MAX_TRIES    = 10,
	parameter int unsigned MAX_WORD_LEN = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [5:0] cfg_data,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_item_t out_item
);
	localparam int unsigned LIM = (MAX_WORD_LEN - 1 > 63) ? 63 : MAX_WORD_LEN - 1;

	logic [5:0]  min_len_q, max_len_q;
	in_item_t    item_q;
	logic [4:0]  lprev_q, lcur_q, gprev_q, gcur_q;
	logic [7:0]  glen_q;
	logic        gvowel_q;
	logic [3:0]  gtries_q;
	logic [15:0] total_q;
	logic [AW-1:0] clr_addr_q;
	logic [4:0]  walk_q;
	out_item_t   out_q;
	out_item_t   out_d;

	// serial divider: remainder of random word by total
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [5:0]  div_cnt_q;
	logic [16:0] trial;

	// memory
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	tmng_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] slot(input logic [4:0] p, input logic [4:0] c,
		input logic [4:0] n);
		return AW'((AW'(p) * AW'(SYMS) + AW'(c)) * AW'(ROWW) + AW'(n));
	endfunction

	logic        is_draw, is_bend;
	logic [4:0]  lsym, ctx_p, ctx_c, rd_n;
	logic [AW-1:0] base_addr;

	assign is_draw = (item_q.opcode == OP_DRAW) || (item_q.opcode == OP_SPARE);
	assign is_bend = (item_q.opcode == OP_LEARN_END);
	assign lsym    = is_bend ? BOUNDARY : item_q.letter;
	assign ctx_p   = is_draw ? gprev_q : lprev_q;
	assign ctx_c   = is_draw ? gcur_q : lcur_q;
	assign rd_n    = cmd.rd_total ? TOT_SLOT : (cmd.rd_sym ? lsym : walk_q);
	assign raddr   = slot(ctx_p, ctx_c, rd_n);
	assign base_addr = slot(lprev_q, lcur_q, cmd.wr_total_inc ? TOT_SLOT : lsym);

	// write port: clearing sweep or increments
	always_comb begin
		we = cmd.clr_step | cmd.wr_total_inc | cmd.wr_sym_inc;
		waddr = cmd.clr_step ? clr_addr_q : base_addr;
		wdata = cmd.clr_step ? 16'd0 : (cmd.wr_total_inc ? total_q + 16'd1 : rdata + 16'd1);
	end

	assign trial = {rem_q[15:0], quo_q[31]} - {1'b0, total_q};

	assign sts.clr_done   = (clr_addr_q == AW'(DEPTH - 1));
	assign sts.is_draw    = is_draw;
	assign sts.bad_letter = (item_q.opcode == OP_LEARN_LETTER) && (item_q.letter >= 5'(ALPHA));
	assign sts.total_full = (rdata == 16'hFFFF);
	assign sts.total_zero = (rdata == 16'd0);
	assign sts.div_done   = (div_cnt_q == 6'd31);
	assign sts.walk_hit   = (walk_q == BOUNDARY) || (rem_q < {1'b0, rdata});

	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '0;
			max_len_q <= 6'd62;
			lprev_q <= BOUNDARY; lcur_q <= BOUNDARY;
			gprev_q <= BOUNDARY; gcur_q <= BOUNDARY;
			glen_q <= '0; gvowel_q <= 1'b0; gtries_q <= '0;
			clr_addr_q <= '0;
		end else begin
			// configuration
			if (cfg_we) begin
				if (cfg_index == REG_MIN_LENGTH) min_len_q <= cfg_data;
				else max_len_q <= cfg_data;
			end
			if (cmd.clr_step && !sts.clr_done)
				clr_addr_q <= clr_addr_q + AW'(1);
			// state updates at end of item
			if (cmd.finish) begin
				if (!is_draw) begin
					if (!sts.bad_letter) begin
						if (is_bend) begin
							lprev_q <= BOUNDARY; lcur_q <= BOUNDARY;
						end else begin
							lprev_q <= lcur_q; lcur_q <= lsym;
						end
					end
				end else if (total_q != 16'd0) begin
					if (walk_q == BOUNDARY) begin
						if (glen_q >= 8'(min_len_q) && gvowel_q) begin
							gprev_q <= BOUNDARY; gcur_q <= BOUNDARY;
							glen_q <= '0; gvowel_q <= 1'b0; gtries_q <= '0;
						end else if (gtries_q + 4'd1 >= 4'(MAX_TRIES)) begin
							gprev_q <= BOUNDARY; gcur_q <= BOUNDARY;
							glen_q <= '0; gvowel_q <= 1'b0; gtries_q <= '0;
						end else
							gtries_q <= gtries_q + 4'd1;
					end else begin
						if (glen_q + 8'd1 > 8'((max_len_q > 6'(LIM)) ? 6'(LIM) : max_len_q)) begin
							gprev_q <= BOUNDARY; gcur_q <= BOUNDARY;
							glen_q <= '0; gvowel_q <= 1'b0; gtries_q <= '0;
						end else begin
							glen_q <= glen_q + 8'd1;
							gvowel_q <= gvowel_q | is_vowel(walk_q);
							gprev_q <= gcur_q; gcur_q <= walk_q;
						end
					end
				end
			end
		end
	end

	// result of the item in flight
	always_comb begin
		out_d = '0;
		if (!is_draw) begin
			out_d.status = (sts.bad_letter || total_q == 16'hFFFF) ? ST_DROPPED : ST_LEARNED;
		end else if (total_q == 16'd0) begin
			out_d.status = ST_EMPTY;
			out_d.word_length = glen_q[5:0];
		end else if (walk_q == BOUNDARY) begin
			if (glen_q >= 8'(min_len_q) && gvowel_q) begin
				out_d.status = ST_DONE;
				out_d.word_length = glen_q[5:0];
			end else begin
				out_d.status = ST_REJECTED;
				if (gtries_q + 4'd1 >= 4'(MAX_TRIES))
					out_d.word_discarded = 1'b1;
				else
					out_d.word_length = glen_q[5:0];
			end
		end else begin
			out_d.status = ST_LETTER;
			out_d.out_letter = walk_q;
			if (glen_q + 8'd1 > 8'((max_len_q > 6'(LIM)) ? 6'(LIM) : max_len_q))
				out_d.word_discarded = 1'b1;
			else
				out_d.word_length = 6'(glen_q + 8'd1);
		end
	end

	// item, divider, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_item)
			item_q <= in_item;
		if (cmd.ld_total)
			total_q <= rdata;
		if (cmd.div_start) begin
			quo_q <= item_q.random_word;
			rem_q <= '0;
			div_cnt_q <= '0;
			walk_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[30:0], 1'b0};
			rem_q <= trial[16] ? {rem_q[15:0], quo_q[31]} : trial;
			div_cnt_q <= div_cnt_q + 6'd1;
		end else if (cmd.walk_chk && !sts.walk_hit) begin
			rem_q <= rem_q - {1'b0, rdata};
			walk_q <= walk_q + 5'd1;
		end
		if (cmd.finish)
			out_q <= out_d;
	end
endmodule

[rtl/core/trigram_markov_name_generator_core.sv]
// Trigram name generator. After reset the count memory (20412 words) is
// cleared one word a cycle, and no item is taken until the sweep ends. Each
// item then runs alone through the sequencer: a learn item reads the total,
// writes the total, then reads and writes the symbol count, or goes straight
// to its result when it is dropped; a draw runs the bit-serial remainder of
// the random word by the context total, then walks symbols (1 to 27) in the
// cumulative count search over the single read port of the count memory,
// reading and checking one symbol at a time. A draw on an empty context skips
// the remainder and the search. The sequencer returns to idle once the result
// leaves and only then takes the next item. One result per item.
module trigram_markov_name_generator_core import tmng_pkg::*; #(
	parameter int unsigned MAX_TRIES    = 10,
	parameter int unsigned MAX_WORD_LEN = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [5:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	cmd_t cmd;
	sts_t sts;

	tmng_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	tmng_dp #(.MAX_TRIES(MAX_TRIES), .MAX_WORD_LEN(MAX_WORD_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts), .out_item(out_item)
	);
endmodule

[rtl/core/tmng_checker.sv]
module tmng_checker import tmng_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);
	// one item at a time: no input taken while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("result changed");
	// letter only on letter status
	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_LETTER |-> out_item.out_letter == 5'd0)
		else $error("stray letter");
	// discard always reports zero length
	a_discard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.word_discarded |-> out_item.word_length == 6'd0)
		else $error("discard with length");
endmodule

bind trigram_markov_name_generator_core tmng_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
